@@ rtl/satt_pkg.sv @@
package satt_pkg;

    localparam int KEY_W = 11;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [1:0] action;
        logic [4:0] alarm_hour;
        logic [5:0] alarm_minute;
        logic [3:0] entry_index;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] entry_count;
        logic [4:0] read_hour;
        logic [5:0] read_minute;
    } result_t;

    // Broadcast from the top level to every cell in the chain.
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [KEY_W-1:0] key;
    } cell_ctrl_t;

    // Position of one cell relative to the count and the delete index.
    typedef struct packed {
        logic occupied;
        logic at_count;
        logic at_or_after_idx;
    } cell_pos_t;

endpackage

@@ rtl/sorted_alarm_time_table_core.sv @@
// Sorted alarm time table.
//
// Command channel: present an item on cmd and raise start; the item is taken
// at the rising edge where start is high and busy is low. busy stays low, so
// an item can be issued in every cycle.
// Result channel: in the cycle after an item is taken, done is high for exactly
// one cycle with the result on result. The receiver cannot stall; every
// result must be captured in its done cycle.
// Throughput: one item per cycle. An insert, delete or read is carried out by
// the chain of compare-and-shift cells, one cell per table slot, each trading
// an entry with its neighbors.
// Reset clears the entry count and the result strobe; table slots are not
// cleared and only slots below the count are ever read.
// Status: ok, duplicate ignored, table full, or index out of range. Unused
// action codes return ok with no change.
module sorted_alarm_time_table_core
    import satt_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  cmd_t    cmd,
    output logic    busy,
    output logic    done,
    output result_t result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
    localparam int RD_N  = (CAPACITY < 16) ? CAPACITY : 16;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    logic             done_next;
    result_t          result_reg;
    result_t          result_next;

    logic [KEY_W-1:0] entry_w [CAPACITY];
    logic [CAPACITY-1:0] gt_w;
    logic [CAPACITY-1:0] eq_w;

    cell_ctrl_t       ctrl;
    logic             accept;
    logic [KEY_W-1:0] key;
    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             dup;
    logic             full;
    logic             idx_ok;
    logic [KEY_W-1:0] rd_entry;

    assign busy    = 1'b0;
    assign done    = done_reg;
    assign result  = result_reg;

    assign accept  = start && !busy;
    assign key     = {cmd.alarm_hour, cmd.alarm_minute};
    assign idx_ext = CMP_W'(cmd.entry_index);
    assign cnt_ext = CMP_W'(count_reg);
    assign dup     = |eq_w;
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign idx_ok  = idx_ext < cnt_ext;

    // Enable the shift only for an insert or delete that will take effect.
    assign ctrl.key = key;
    assign ctrl.ins = accept && (cmd.action == ACT_INSERT) && !dup && !full;
    assign ctrl.del = accept && (cmd.action == ACT_DELETE) && idx_ok;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        cell_pos_t        pos;
        logic [KEY_W-1:0] left_entry;
        logic             left_gt;
        logic [KEY_W-1:0] right_entry;

        assign pos.occupied        = CMP_W'(i) < cnt_ext;
        assign pos.at_count        = CMP_W'(i) == cnt_ext;
        assign pos.at_or_after_idx = CMP_W'(i) >= idx_ext;

        if (i == 0)
        begin : g_first
            assign left_entry = key;
            assign left_gt    = 1'b0;
        end
        else
        begin : g_mid
            assign left_entry = entry_w[i-1];
            assign left_gt    = gt_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_entry = '0;
        end
        else
        begin : g_inner
            assign right_entry = entry_w[i+1];
        end

        satt_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .pos         (pos),
            .left_entry  (left_entry),
            .left_gt     (left_gt),
            .right_entry (right_entry),
            .entry       (entry_w[i]),
            .gt          (gt_w[i]),
            .eq          (eq_w[i])
        );
    end

    // Select the read slot; the index field reaches only the first slots.
    always_comb
    begin
        rd_entry = '0;
        for (int i = 0; i < RD_N; i++)
        begin
            if (cmd.entry_index == 4'(i))
            begin
                rd_entry = entry_w[i];
            end
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        done_next   = accept;
        result_next = '0;
        if (ctrl.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.del)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        case (cmd.action)
            ACT_INSERT:
            begin
                if (dup)
                begin
                    result_next.status = ST_DUP;
                end
                else if (full)
                begin
                    result_next.status = ST_FULL;
                end
                else
                begin
                    result_next.status = ST_OK;
                end
            end
            ACT_DELETE:
            begin
                result_next.status = idx_ok ? ST_OK : ST_RANGE;
            end
            ACT_READ:
            begin
                if (idx_ok)
                begin
                    result_next.status      = ST_OK;
                    result_next.read_hour   = rd_entry[KEY_W-1:6];
                    result_next.read_minute = rd_entry[5:0];
                end
                else
                begin
                    result_next.status = ST_RANGE;
                end
            end
            default:
            begin
                result_next.status = ST_OK;
            end
        endcase
        result_next.entry_count = 5'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Hold the result payload; only the strobe needs a reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

endmodule

@@ rtl/satt_cell.sv @@
module satt_cell
    import satt_pkg::*;
(
    input  logic             clk,
    input  cell_ctrl_t       ctrl,
    input  cell_pos_t        pos,
    input  logic [KEY_W-1:0] left_entry,
    input  logic             left_gt,
    input  logic [KEY_W-1:0] right_entry,
    output logic [KEY_W-1:0] entry,
    output logic             gt,
    output logic             eq
);

    logic [KEY_W-1:0] entry_reg;
    logic [KEY_W-1:0] entry_next;

    assign entry = entry_reg;
    assign gt    = pos.occupied && (entry_reg > ctrl.key);
    assign eq    = pos.occupied && (entry_reg == ctrl.key);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            // Shift up when the left neighbor moves out of the way of the key.
            if (left_gt)
            begin
                entry_next = left_entry;
            end
            else if (gt || pos.at_count)
            begin
                entry_next = ctrl.key;
            end
        end
        else if (ctrl.del)
        begin
            // Close the gap: take the right neighbor from the deleted slot on.
            if (pos.occupied && pos.at_or_after_idx)
            begin
                entry_next = right_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

@@ tb/tb.sv @@
module tb;
    import satt_pkg::*;

    localparam int CAPACITY = 16;
    // The block answers action code 3 with ok and no change; the package has no name for it.
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    // Settle time after the last result before calling the run finished.
    localparam int SETTLE_CYCLES = 4;
    // Room for about 1300 items and their sender pauses, many times over.
    localparam int CYCLE_LIMIT = 200000;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    cmd = '0;
    logic    busy;
    logic    done;
    result_t result;

    sorted_alarm_time_table_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .cmd(cmd),
        .busy(busy),
        .done(done),
        .result(result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the alarm table: sorted keys of hour*64 + minute, and the count.
    logic [KEY_W-1:0] alarm_keys [CAPACITY];
    int unsigned      alarm_count = 0;

    // Results that the block still owes, oldest first.
    result_t          owed_results [$];
    int unsigned      mismatch_count = 0;
    int unsigned      cycle_count = 0;
    bit               idling_on = 1'b0;

    // ------------------------------------------------------------------
    // Table predictor
    // ------------------------------------------------------------------

    function automatic bit key_stored(logic [KEY_W-1:0] key);
        for (int i = 0; i < alarm_count; i++)
        begin
            if (alarm_keys[i] == key)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Apply one accepted item to the shadow table and return the result it owes.
    function automatic result_t apply_alarm_cmd(cmd_t c);
        result_t          r;
        logic [KEY_W-1:0] key;
        int               pos;
        r = '0;
        key = {c.alarm_hour, c.alarm_minute};
        case (c.action)
            ACT_INSERT:
            begin
                // The duplicate check wins over the full check.
                if (key_stored(key))
                    r.status = ST_DUP;
                else if (alarm_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    // Shift larger keys up one slot, then drop the new key into the hole.
                    pos = alarm_count;
                    while (pos > 0 && alarm_keys[pos-1] > key)
                    begin
                        alarm_keys[pos] = alarm_keys[pos-1];
                        pos--;
                    end
                    alarm_keys[pos] = key;
                    alarm_count++;
                    r.status = ST_OK;
                end
            end
            ACT_DELETE:
            begin
                if (c.entry_index >= alarm_count)
                    r.status = ST_RANGE;
                else
                begin
                    // Later entries move down one place to close the gap.
                    for (int i = c.entry_index; i + 1 < alarm_count; i++)
                        alarm_keys[i] = alarm_keys[i+1];
                    alarm_count--;
                    r.status = ST_OK;
                end
            end
            ACT_READ:
            begin
                if (c.entry_index >= alarm_count)
                    r.status = ST_RANGE;
                else
                begin
                    {r.read_hour, r.read_minute} = alarm_keys[c.entry_index];
                    r.status = ST_OK;
                end
            end
            default:
                r.status = ST_OK;
        endcase
        r.entry_count = alarm_count[4:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Item construction
    // ------------------------------------------------------------------

    function automatic cmd_t make_cmd(logic [1:0] action, int hour, int minute, int index);
        cmd_t c;
        c.action = action;
        c.alarm_hour = hour[4:0];
        c.alarm_minute = minute[5:0];
        c.entry_index = index[3:0];
        return c;
    endfunction

    // Random item shaped by the current table: inserts mostly use clock times, some
    // hit a stored time on purpose, and most indexes land on a stored entry.
    function automatic cmd_t random_alarm_cmd(int unsigned insert_pct, int unsigned delete_pct);
        cmd_t        c;
        int unsigned roll;
        c = cmd_t'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < insert_pct)
        begin
            c.action = ACT_INSERT;
            if (alarm_count > 0 && $urandom_range(0, 5) == 0)
                {c.alarm_hour, c.alarm_minute} = alarm_keys[$urandom_range(0, alarm_count - 1)];
            else if ($urandom_range(0, 7) != 0)
            begin
                c.alarm_hour = 5'($urandom_range(0, 23));
                c.alarm_minute = 6'($urandom_range(0, 59));
            end
            // otherwise keep the full 5- and 6-bit range, past the clock limits
        end
        else if (roll < insert_pct + delete_pct)
            c.action = ACT_DELETE;
        else if (roll < 97)
            c.action = ACT_READ;
        else
            c.action = ACT_UNUSED;
        if (c.action != ACT_INSERT && alarm_count > 0 && $urandom_range(0, 4) != 0)
            c.entry_index = 4'($urandom_range(0, alarm_count - 1));
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Hold start low for a number of cycles, with noise on cmd that must be ignored.
    task automatic pause_sender(int unsigned cycles);
        start <= 1'b0;
        cmd <= cmd_t'($urandom);
        repeat (cycles) @(posedge clk);
    endtask

    // Present one item and hold it until the block takes it. start is left high so
    // that the next item can follow in the very next cycle.
    task automatic send_cmd(cmd_t c);
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        owed_results.insert(owed_results.size(), apply_alarm_cmd(c));
        if (idling_on && $urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 10));
    endtask

    // Stop sending until the block has paid every result it owes.
    task automatic wait_for_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (owed_results.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Result checking: every strobe is matched to the oldest owed result.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (done)
        begin
            if (owed_results.size() == 0)
            begin
                $error("unexpected result strobe, result %p", result);
                mismatch_count++;
            end
            else
            begin
                want = owed_results.pop_front();
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    mismatch_count++;
                end
                if (result.entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, result.entry_count);
                    mismatch_count++;
                end
                if (result.read_hour !== want.read_hour)
                begin
                    $error("read_hour: expected %0d, got %0d", want.read_hour, result.read_hour);
                    mismatch_count++;
                end
                if (result.read_minute !== want.read_minute)
                begin
                    $error("read_minute: expected %0d, got %0d",
                           want.read_minute, result.read_minute);
                    mismatch_count++;
                end
            end
        end
    end

    // Guard against a hung handshake or a result that never arrives.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty table, clock extremes, times past the clock range, duplicates,
    // out-of-range indexes, deletes at both ends and in the middle, unused action.
    task automatic test_edge_cases();
        send_cmd(make_cmd(ACT_READ, 0, 0, 0));         // read of an empty table
        send_cmd(make_cmd(ACT_DELETE, 31, 63, 15));    // delete from an empty table
        send_cmd(make_cmd(ACT_UNUSED, 31, 63, 15));    // unused action, all ones
        send_cmd(make_cmd(ACT_INSERT, 23, 59, 0));
        send_cmd(make_cmd(ACT_INSERT, 0, 0, 15));
        send_cmd(make_cmd(ACT_INSERT, 31, 63, 0));     // largest key the fields allow
        send_cmd(make_cmd(ACT_INSERT, 24, 60, 0));     // past the clock range, sorts above 23:59
        send_cmd(make_cmd(ACT_INSERT, 12, 30, 0));     // lands in the middle
        send_cmd(make_cmd(ACT_INSERT, 23, 59, 3));     // duplicate
        send_cmd(make_cmd(ACT_READ, 0, 0, 0));
        send_cmd(make_cmd(ACT_READ, 31, 63, 4));
        send_cmd(make_cmd(ACT_READ, 0, 0, 5));         // first index past the end
        send_cmd(make_cmd(ACT_READ, 0, 0, 15));
        send_cmd(make_cmd(ACT_DELETE, 0, 0, 15));
        send_cmd(make_cmd(ACT_DELETE, 0, 0, 4));       // last entry
        send_cmd(make_cmd(ACT_DELETE, 0, 0, 0));       // first entry
        send_cmd(make_cmd(ACT_DELETE, 0, 0, 1));       // middle entry
        send_cmd(make_cmd(ACT_READ, 0, 0, 0));
        send_cmd(make_cmd(ACT_READ, 0, 0, 1));
        send_cmd(make_cmd(ACT_INSERT, 0, 63, 0));
        send_cmd(make_cmd(ACT_INSERT, 31, 0, 0));
        send_cmd(make_cmd(ACT_UNUSED, 0, 0, 0));
        send_cmd(make_cmd(ACT_READ, 0, 0, 3));
        wait_for_results();
    endtask

    // Fill the table to capacity, hit it with a new time and a stored one, then drain it.
    task automatic test_full_table();
        cmd_t c;
        while (alarm_count < CAPACITY)
            send_cmd(random_alarm_cmd(100, 0));
        // New time into a full table: make sure it really is new.
        do
            c = make_cmd(ACT_INSERT, $urandom_range(0, 31), $urandom_range(0, 63), 0);
        while (key_stored({c.alarm_hour, c.alarm_minute}));
        send_cmd(c);
        // Stored time into a full table: duplicate must win over full.
        c.alarm_hour = alarm_keys[7][10:6];
        c.alarm_minute = alarm_keys[7][5:0];
        send_cmd(c);
        send_cmd(make_cmd(ACT_READ, 0, 0, 15));
        send_cmd(make_cmd(ACT_READ, 0, 0, 0));
        send_cmd(make_cmd(ACT_DELETE, 0, 0, 15));
        send_cmd(make_cmd(ACT_READ, 0, 0, 15));
        while (alarm_count > 0)
            send_cmd(make_cmd(ACT_DELETE, 0, 0, $urandom_range(0, alarm_count - 1)));
        send_cmd(make_cmd(ACT_READ, 0, 0, 0));
        // Pause until the block is quiet before the random traffic starts.
        wait_for_results();
    endtask

    // Alternate fill-heavy and drain-heavy stretches so the table keeps sweeping
    // between empty and full; hold the sender at the end of every round.
    task automatic test_random_traffic(int unsigned rounds, int unsigned per_phase);
        for (int r = 0; r < rounds; r++)
        begin
            repeat (per_phase) send_cmd(random_alarm_cmd(75, 10));
            repeat (per_phase) send_cmd(random_alarm_cmd(15, 60));
            wait_for_results();
        end
    endtask

    // Closing stretch with an item in every cycle.
    task automatic test_back_to_back(int unsigned count);
        for (int i = 0; i < count; i++)
            send_cmd(random_alarm_cmd(i < count / 2 ? 70 : 20, i < count / 2 ? 10 : 50));
        pause_sender(1);
    endtask

    initial
    begin
        // Hold reset low from the start, then release it on a clock edge.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idling_on = 1'b1;
        test_edge_cases();
        test_full_table();
        test_random_traffic(10, 55);
        idling_on = 1'b0;
        test_back_to_back(120);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
